/* sv/rect_fill_alpha_over_blend_defines.svh */
// ----------------------------------------------------------------------------
// rect_fill_alpha_over_blend_defines
// Assertion macros shared by the rectangle fill blend.
// ----------------------------------------------------------------------------
`ifndef RECT_FILL_ALPHA_OVER_BLEND_DEFINES_SVH
`define RECT_FILL_ALPHA_OVER_BLEND_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RFAB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RFAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rfab_pkg.sv */
// ----------------------------------------------------------------------------
// rfab_pkg
// Widths, constants, register codes and divider types of the rectangle fill
// blend.
// ----------------------------------------------------------------------------
package rfab_pkg;

  // field widths
  localparam int CHAN_W     = 8;
  localparam int CHANNELS   = 3;
  localparam int POS_W      = 14;
  localparam int DIM_W      = 15;
  localparam int EDGE_W     = 16;
  localparam int PIX_W      = 32;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // frame size limit
  localparam logic [DIM_W-1:0] MAX_DIMENSION = DIM_W'(16384);

  // rounding and channel limits
  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam logic [CHAN_W-1:0] ROUND_HALF = 8'd127;

  // x / 255 as (x * m) >> s, exact for x below 2^16 and below 2^24
  localparam int                RECIP16_W     = 16;
  localparam logic [15:0]       RECIP16       = 16'd32897;
  localparam int                RECIP16_SHIFT = 23;
  localparam int                RECIP24_W     = 24;
  localparam logic [23:0]       RECIP24       = 24'd8421505;
  localparam int                RECIP24_SHIFT = 31;

  // widths of the blend terms
  localparam int PROD_W = 2 * CHAN_W;   // 8 x 8 products
  localparam int TRIP_W = 3 * CHAN_W;   // 8 x 8 x 8 products
  localparam int REM_W  = PROD_W + 2;   // sum of two products plus rounding

  // pipeline shape
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = 4;
  localparam int DIV_BITS     = CHAN_W / DIV_STAGES;
  localparam int STAGES       = FRONT_STAGES + DIV_STAGES;

  // reset values of the registers
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = DIM_W'(1280);
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = DIM_W'(720);
  localparam logic [CHAN_W-1:0]  RST_FILL_ALPHA   = 8'd255;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_RECT_LEFT    = 4'd2,
    REG_RECT_TOP     = 4'd3,
    REG_RECT_RIGHT   = 4'd4,
    REG_RECT_BOTTOM  = 4'd5,
    REG_FILL_COLOR   = 4'd6,
    REG_FILL_ALPHA   = 4'd7
  } cfg_reg_t;

  // operands entering one channel divider
  typedef struct packed {
    logic [REM_W-1:0]  num;
    logic [CHAN_W-1:0] oa;
    logic              sat;
  } div_in_t;

  // per-stage advance strobes of the divider
  typedef logic [DIV_STAGES-1:0] div_en_t;

endpackage

/* sv/rfab_div.sv */
// ----------------------------------------------------------------------------
// rfab_div
// Pipelined restoring divider for one color channel: two quotient bits per
// stage, saturated to the channel maximum when the quotient overflows.
// ----------------------------------------------------------------------------
module rfab_div (
  input  logic                        clk,
  input  rfab_pkg::div_en_t           en,
  input  rfab_pkg::div_in_t           din,
  output logic [rfab_pkg::CHAN_W-1:0] quo
);

  localparam int LAST = rfab_pkg::DIV_STAGES - 1;

  // stage registers; remainder and divisor are not needed after the last stage
  logic [rfab_pkg::REM_W-1:0]  rem   [rfab_pkg::DIV_STAGES-1];
  logic [rfab_pkg::CHAN_W-1:0] dvs   [rfab_pkg::DIV_STAGES-1];
  logic [rfab_pkg::CHAN_W-1:0] quo_r [rfab_pkg::DIV_STAGES];
  logic                        sat   [rfab_pkg::DIV_STAGES];

  for (genvar k = 0; k < rfab_pkg::DIV_STAGES; k++) begin : g_stage
    logic [rfab_pkg::REM_W-1:0]  rem_s;
    logic [rfab_pkg::REM_W-1:0]  rem_d;
    logic [rfab_pkg::CHAN_W-1:0] q_s;
    logic [rfab_pkg::CHAN_W-1:0] q_d;
    logic [rfab_pkg::CHAN_W-1:0] d_s;
    logic                        sat_s;

    // stage source
    if (k == 0) begin : g_first
      assign rem_s = din.num;
      assign q_s   = '0;
      assign d_s   = din.oa;
      assign sat_s = din.sat;
    end else begin : g_next
      assign rem_s = rem[k-1];
      assign q_s   = quo_r[k-1];
      assign d_s   = dvs[k-1];
      assign sat_s = sat[k-1];
    end

    // compare and subtract, msb first
    always_comb begin
      rem_d = rem_s;
      q_d   = q_s;
      for (int j = 0; j < rfab_pkg::DIV_BITS; j++) begin
        if (rem_d >= (rfab_pkg::REM_W'(d_s)
                      << (rfab_pkg::CHAN_W - 1 - k * rfab_pkg::DIV_BITS - j))) begin
          rem_d = rem_d - (rfab_pkg::REM_W'(d_s)
                           << (rfab_pkg::CHAN_W - 1 - k * rfab_pkg::DIV_BITS - j));
          q_d[rfab_pkg::CHAN_W - 1 - k * rfab_pkg::DIV_BITS - j] = 1'b1;
        end
      end
    end

    // quotient and overflow flag
    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo_r[k] <= q_d;
        sat[k]   <= sat_s;
      end
    end

    // partial remainder and divisor for the following stage
    if (k < LAST) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= rem_d;
          dvs[k] <= d_s;
        end
      end
    end
  end

  // saturate overflowing quotients
  assign quo = sat[LAST] ? rfab_pkg::CHAN_MAX : quo_r[LAST];

endmodule

/* sv/rect_fill_alpha_over_blend.sv */
// ----------------------------------------------------------------------------
// rect_fill_alpha_over_blend
// Fills a clamped rectangle of a pixel stream with a constant color, blended
// source-over in straight alpha.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low and returns one result per
// pixel in order, carried from acceptance to out_valid through nine register
// stages. The depth is set by the five front stages (capture, coverage and
// products, output alpha, the divisions by 255, channel numerators) and the
// four-stage quotient pipeline that divides each channel by the output alpha,
// two bits per stage. Every stage has its own valid bit and advances whenever
// the stage after it can take its item, so in_stall rises only when the whole
// pipeline is full and the output is stalled. Registers are written through
// the cfg port, which is always ready; write them only while no item is in
// flight. Indexes above seven are ignored.
`include "rect_fill_alpha_over_blend_defines.svh"

module rect_fill_alpha_over_blend (
  input  logic                            clk,
  input  logic                            rst,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rfab_pkg::POS_W-1:0]      pos_x,
  input  logic [rfab_pkg::POS_W-1:0]      pos_y,
  input  logic [rfab_pkg::PIX_W-1:0]      dst_pixel,
  // pixel output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rfab_pkg::PIX_W-1:0]      out_pixel,
  output logic                            covered,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfab_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = rfab_pkg::CHAN_W;
  localparam int NCH = rfab_pkg::CHANNELS;
  localparam int PW  = rfab_pkg::PROD_W;
  localparam int TW  = rfab_pkg::TRIP_W;
  localparam int FS  = rfab_pkg::FRONT_STAGES;
  localparam int DS  = rfab_pkg::DIV_STAGES;

  // configuration registers
  logic [rfab_pkg::DIM_W-1:0]         frame_width;
  logic [rfab_pkg::DIM_W-1:0]         frame_height;
  logic signed [rfab_pkg::EDGE_W-1:0] rect_left;
  logic signed [rfab_pkg::EDGE_W-1:0] rect_top;
  logic signed [rfab_pkg::EDGE_W-1:0] rect_right;
  logic signed [rfab_pkg::EDGE_W-1:0] rect_bottom;
  logic [rfab_pkg::COLOR_W-1:0]       fill_color;
  logic [CW-1:0]                      fill_alpha;

  // stage valid bits and advance strobes
  logic [rfab_pkg::STAGES-1:0] vld;
  logic [rfab_pkg::STAGES-1:0] adv;

  // stage 1: captured item
  logic [rfab_pkg::POS_W-1:0] s1_x;
  logic [rfab_pkg::POS_W-1:0] s1_y;
  logic [rfab_pkg::PIX_W-1:0] s1_dst;
  // stage 2: coverage and 8 x 8 products
  logic [rfab_pkg::PIX_W-1:0] s2_dst;
  logic                       s2_hit;
  logic [PW-1:0]              s2_dainv;
  logic [PW-1:0]              s2_dcda [NCH];
  logic [PW-1:0]              s2_scsa [NCH];
  // stage 3: output alpha and destination triple products
  logic [rfab_pkg::PIX_W-1:0] s3_dst;
  logic                       s3_hit;
  logic [CW-1:0]              s3_oa;
  logic [TW-1:0]              s3_pd   [NCH];
  logic [PW-1:0]              s3_scsa [NCH];
  // stage 4: destination terms divided by 255
  logic [rfab_pkg::PIX_W-1:0] s4_dst;
  logic                       s4_hit;
  logic [CW-1:0]              s4_oa;
  logic [PW-1:0]              s4_dq   [NCH];
  logic [PW-1:0]              s4_scsa [NCH];
  // stage 5: divider operands
  logic [rfab_pkg::PIX_W-1:0] s5_dst;
  logic                       s5_hit;
  logic [CW-1:0]              s5_oa;
  rfab_pkg::div_in_t          s5_div  [NCH];
  // side data riding along the divider stages
  logic [rfab_pkg::PIX_W-1:0] sd_dst  [DS];
  logic                       sd_hit  [DS];
  logic [CW-1:0]              sd_oa   [DS];
  logic [CW-1:0]              quo     [NCH];

  // clamped rectangle
  logic [rfab_pkg::DIM_W-1:0] dim_w;
  logic [rfab_pkg::DIM_W-1:0] dim_h;
  logic [rfab_pkg::DIM_W-1:0] clip_l;
  logic [rfab_pkg::DIM_W-1:0] clip_r;
  logic [rfab_pkg::DIM_W-1:0] clip_t;
  logic [rfab_pkg::DIM_W-1:0] clip_b;
  logic                       hit_c;
  logic [CW-1:0]              inv_a;
  logic [PW-1:0]              oa_prod_hi;
  logic [CW-1:0]              oa_c;

  // register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rfab_pkg::RST_FRAME_WIDTH;
      frame_height <= rfab_pkg::RST_FRAME_HEIGHT;
      rect_left    <= '0;
      rect_top     <= '0;
      rect_right   <= '0;
      rect_bottom  <= '0;
      fill_color   <= '0;
      fill_alpha   <= rfab_pkg::RST_FILL_ALPHA;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rfab_pkg::cfg_reg_t'(cfg_index))
        rfab_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[rfab_pkg::DIM_W-1:0];
        rfab_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[rfab_pkg::DIM_W-1:0];
        rfab_pkg::REG_RECT_LEFT:    rect_left    <= cfg_data[rfab_pkg::EDGE_W-1:0];
        rfab_pkg::REG_RECT_TOP:     rect_top     <= cfg_data[rfab_pkg::EDGE_W-1:0];
        rfab_pkg::REG_RECT_RIGHT:   rect_right   <= cfg_data[rfab_pkg::EDGE_W-1:0];
        rfab_pkg::REG_RECT_BOTTOM:  rect_bottom  <= cfg_data[rfab_pkg::EDGE_W-1:0];
        rfab_pkg::REG_FILL_COLOR:   fill_color   <= cfg_data[rfab_pkg::COLOR_W-1:0];
        rfab_pkg::REG_FILL_ALPHA:   fill_alpha   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: a stage takes a new item when empty or when it hands on
  always_comb begin
    adv[rfab_pkg::STAGES-1] = !vld[rfab_pkg::STAGES-1] || !out_stall;
    for (int k = rfab_pkg::STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[rfab_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < rfab_pkg::STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // frame size limit and edge clamping
  assign dim_w  = (frame_width  > rfab_pkg::MAX_DIMENSION) ? rfab_pkg::MAX_DIMENSION
                                                           : frame_width;
  assign dim_h  = (frame_height > rfab_pkg::MAX_DIMENSION) ? rfab_pkg::MAX_DIMENSION
                                                           : frame_height;
  assign clip_l = rect_left[rfab_pkg::EDGE_W-1] ? '0 :
                  (rect_left   > $signed({1'b0, dim_w})) ? dim_w
                                                         : rect_left[rfab_pkg::DIM_W-1:0];
  assign clip_r = rect_right[rfab_pkg::EDGE_W-1] ? '0 :
                  (rect_right  > $signed({1'b0, dim_w})) ? dim_w
                                                         : rect_right[rfab_pkg::DIM_W-1:0];
  assign clip_t = rect_top[rfab_pkg::EDGE_W-1] ? '0 :
                  (rect_top    > $signed({1'b0, dim_h})) ? dim_h
                                                         : rect_top[rfab_pkg::DIM_W-1:0];
  assign clip_b = rect_bottom[rfab_pkg::EDGE_W-1] ? '0 :
                  (rect_bottom > $signed({1'b0, dim_h})) ? dim_h
                                                         : rect_bottom[rfab_pkg::DIM_W-1:0];

  // coverage test on the captured item
  assign hit_c = (fill_alpha != '0)
              && (rfab_pkg::DIM_W'(s1_x) >= clip_l) && (rfab_pkg::DIM_W'(s1_x) < clip_r)
              && (rfab_pkg::DIM_W'(s1_y) >= clip_t) && (rfab_pkg::DIM_W'(s1_y) < clip_b);

  // 255 - sa is the bitwise inverse in eight bits
  assign inv_a = ~fill_alpha;

  // output alpha: sa + round(da * inv / 255)
  assign oa_prod_hi = PW'(((2 * PW)'(s2_dainv + PW'(rfab_pkg::ROUND_HALF))
                           * (2 * PW)'(rfab_pkg::RECIP16)) >> rfab_pkg::RECIP16_SHIFT);
  assign oa_c = fill_alpha + oa_prod_hi[CW-1:0];

  // front stages
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_x   <= pos_x;
      s1_y   <= pos_y;
      s1_dst <= dst_pixel;
    end
    if (adv[1]) begin
      s2_dst   <= s1_dst;
      s2_hit   <= hit_c;
      s2_dainv <= PW'(s1_dst[rfab_pkg::PIX_W-1 -: CW]) * PW'(inv_a);
      for (int c = 0; c < NCH; c++) begin
        s2_dcda[c] <= PW'(s1_dst[c*CW +: CW]) * PW'(s1_dst[rfab_pkg::PIX_W-1 -: CW]);
        s2_scsa[c] <= PW'(fill_color[c*CW +: CW]) * PW'(fill_alpha);
      end
    end
    if (adv[2]) begin
      s3_dst <= s2_dst;
      s3_hit <= s2_hit;
      s3_oa  <= oa_c;
      for (int c = 0; c < NCH; c++) begin
        s3_pd[c]   <= TW'(s2_dcda[c]) * TW'(inv_a);
        s3_scsa[c] <= s2_scsa[c];
      end
    end
    if (adv[3]) begin
      s4_dst <= s3_dst;
      s4_hit <= s3_hit;
      s4_oa  <= s3_oa;
      for (int c = 0; c < NCH; c++) begin
        s4_dq[c]   <= PW'(((2 * TW)'(s3_pd[c] + TW'(rfab_pkg::ROUND_HALF))
                           * (2 * TW)'(rfab_pkg::RECIP24)) >> rfab_pkg::RECIP24_SHIFT);
        s4_scsa[c] <= s3_scsa[c];
      end
    end
    if (adv[4]) begin
      s5_dst <= s4_dst;
      s5_hit <= s4_hit;
      s5_oa  <= s4_oa;
      for (int c = 0; c < NCH; c++) begin
        s5_div[c].num <= rfab_pkg::REM_W'(s4_scsa[c]) + rfab_pkg::REM_W'(s4_dq[c])
                       + rfab_pkg::REM_W'(s4_oa >> 1);
        s5_div[c].oa  <= s4_oa;
        s5_div[c].sat <= (rfab_pkg::REM_W'(s4_scsa[c]) + rfab_pkg::REM_W'(s4_dq[c])
                          + rfab_pkg::REM_W'(s4_oa >> 1))
                         >= rfab_pkg::REM_W'({s4_oa, {CW{1'b0}}});
      end
    end
  end

  // pass-through data alongside the divider
  always_ff @(posedge clk) begin
    for (int k = 0; k < DS; k++) begin
      if (adv[FS+k]) begin
        if (k == 0) begin
          sd_dst[k] <= s5_dst;
          sd_hit[k] <= s5_hit;
          sd_oa[k]  <= s5_oa;
        end else begin
          sd_dst[k] <= sd_dst[k-1];
          sd_hit[k] <= sd_hit[k-1];
          sd_oa[k]  <= sd_oa[k-1];
        end
      end
    end
  end

  // one divider per color channel
  for (genvar c = 0; c < NCH; c++) begin : g_chan
    rfab_div u_div (
      .clk (clk),
      .en  (rfab_pkg::div_en_t'(adv[rfab_pkg::STAGES-1:FS])),
      .din (s5_div[c]),
      .quo (quo[c])
    );
  end

  // result assembly
  assign covered   = sd_hit[DS-1];
  assign out_pixel = sd_hit[DS-1] ? {sd_oa[DS-1], quo[2], quo[1], quo[0]}
                                  : sd_dst[DS-1];

  // checks
  `RFAB_ASSERT_IMPL(a_cover_needs_alpha, clk, rst, out_valid && covered, fill_alpha != '0, "covered item with fill alpha zero")
  `RFAB_ASSERT_IMPL(a_cover_alpha_nonzero, clk, rst, out_valid && covered, out_pixel[rfab_pkg::PIX_W-1 -: CW] != '0, "covered item with zero output alpha")
  `RFAB_ASSERT_IMPL(a_opaque_fill, clk, rst, out_valid && covered && fill_alpha == rfab_pkg::CHAN_MAX, out_pixel[rfab_pkg::PIX_W-1 -: CW] == rfab_pkg::CHAN_MAX, "opaque fill left output alpha below maximum")
  `RFAB_ASSERT_IMPL(a_stall_when_full, clk, rst, in_stall, vld[0] && out_valid && out_stall, "input stalled while the pipeline has room")
  `RFAB_ASSERT_NEXT(a_front_holds, clk, rst, vld[0] && !adv[0], vld[0] && $stable(s1_dst), "first stage lost its item while blocked")

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the rectangle fill blend: directed edge, clamp and alpha
// cases, then randomized rectangles and pixels, with and without bursty idling on
// both sides, every result checked against a cycle-free software blend.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  // index past the register list; its low bits match the right edge index
  localparam logic [rfab_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 4'd12;

  typedef struct {
    logic [rfab_pkg::PIX_W-1:0] pixel;
    logic                       cov;
  } blend_result_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [rfab_pkg::POS_W-1:0]      pos_x;
  logic [rfab_pkg::POS_W-1:0]      pos_y;
  logic [rfab_pkg::PIX_W-1:0]      dst_pixel;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [rfab_pkg::PIX_W-1:0]      out_pixel;
  logic                            covered;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rfab_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rfab_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the block registers
  logic [rfab_pkg::DIM_W-1:0]         m_frame_w;
  logic [rfab_pkg::DIM_W-1:0]         m_frame_h;
  logic signed [rfab_pkg::EDGE_W-1:0] m_left;
  logic signed [rfab_pkg::EDGE_W-1:0] m_top;
  logic signed [rfab_pkg::EDGE_W-1:0] m_right;
  logic signed [rfab_pkg::EDGE_W-1:0] m_bottom;
  logic [rfab_pkg::COLOR_W-1:0]       m_color;
  logic [rfab_pkg::CHAN_W-1:0]        m_alpha;

  blend_result_t pending_px[$];
  blend_result_t want;
  int            fail_count  = 0;
  int            cycle_count = 0;
  int            stall_left  = 0;
  bit            idling      = 1'b1;

  rect_fill_alpha_over_blend DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .dst_pixel (dst_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .covered   (covered),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // frame dimension after saturation
  function automatic int frame_span(input logic [rfab_pkg::DIM_W-1:0] d);
    return (d > rfab_pkg::MAX_DIMENSION) ? int'(rfab_pkg::MAX_DIMENSION) : int'(d);
  endfunction

  // edge clamped into 0 .. hi
  function automatic int edge_clip(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // expected result of one pixel under the current registers
  function automatic blend_result_t predict_px(input logic [rfab_pkg::POS_W-1:0] x,
                                               input logic [rfab_pkg::POS_W-1:0] y,
                                               input logic [rfab_pkg::PIX_W-1:0] dst);
    blend_result_t r;
    int w, h, l, rt, t, b;
    int unsigned sa, da, inv, oa, sc, dc, prem, q;
    w  = frame_span(m_frame_w);
    h  = frame_span(m_frame_h);
    l  = edge_clip(m_left, w);
    rt = edge_clip(m_right, w);
    t  = edge_clip(m_top, h);
    b  = edge_clip(m_bottom, h);
    r.pixel = dst;
    r.cov = (m_alpha != 0) && (int'(x) >= l) && (int'(x) < rt) &&
            (int'(y) >= t) && (int'(y) < b);
    if (r.cov) begin
      sa  = 32'(m_alpha);
      da  = 32'(dst[31:24]);
      inv = 32'(rfab_pkg::CHAN_MAX) - sa;
      oa  = sa + (da * inv + 32'(rfab_pkg::ROUND_HALF)) / 32'(rfab_pkg::CHAN_MAX);
      r.pixel[31:24] = oa[7:0];
      for (int i = 0; i < rfab_pkg::CHANNELS; i++) begin
        sc   = 32'(m_color[8*i +: 8]);
        dc   = 32'(dst[8*i +: 8]);
        prem = sc * sa + (dc * da * inv + 32'(rfab_pkg::ROUND_HALF))
               / 32'(rfab_pkg::CHAN_MAX);
        q    = (prem + oa / 2) / oa;
        if (q > 32'(rfab_pkg::CHAN_MAX)) q = 32'(rfab_pkg::CHAN_MAX);
        r.pixel[8*i +: 8] = q[7:0];
      end
    end
    return r;
  endfunction

  // register write as the block sees it
  function automatic void shadow_write(input logic [rfab_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [rfab_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rfab_pkg::REG_FRAME_WIDTH:  m_frame_w = data[rfab_pkg::DIM_W-1:0];
      rfab_pkg::REG_FRAME_HEIGHT: m_frame_h = data[rfab_pkg::DIM_W-1:0];
      rfab_pkg::REG_RECT_LEFT:    m_left    = data[rfab_pkg::EDGE_W-1:0];
      rfab_pkg::REG_RECT_TOP:     m_top     = data[rfab_pkg::EDGE_W-1:0];
      rfab_pkg::REG_RECT_RIGHT:   m_right   = data[rfab_pkg::EDGE_W-1:0];
      rfab_pkg::REG_RECT_BOTTOM:  m_bottom  = data[rfab_pkg::EDGE_W-1:0];
      rfab_pkg::REG_FILL_COLOR:   m_color   = data[rfab_pkg::COLOR_W-1:0];
      rfab_pkg::REG_FILL_ALPHA:   m_alpha   = data[rfab_pkg::CHAN_W-1:0];
      default: ;
    endcase
  endfunction

  // drive one register write and wait for the handshake
  task automatic cfg_write(input logic [rfab_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfab_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_write(idx, data);
  endtask

  task automatic cfg_finish();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rect(input int l, input int t, input int r, input int b);
    cfg_write(rfab_pkg::REG_RECT_LEFT, 32'(l));
    cfg_write(rfab_pkg::REG_RECT_TOP, 32'(t));
    cfg_write(rfab_pkg::REG_RECT_RIGHT, 32'(r));
    cfg_write(rfab_pkg::REG_RECT_BOTTOM, 32'(b));
  endtask

  // present one pixel item, optionally after a gap, and log its expectation
  task automatic send_pixel(input logic [rfab_pkg::POS_W-1:0] x,
                            input logic [rfab_pkg::POS_W-1:0] y,
                            input logic [rfab_pkg::PIX_W-1:0] d);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    pos_x     <= x;
    pos_y     <= y;
    dst_pixel <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_px.push_back(predict_px(x, y, d));
  endtask

  // stop sending, let every result drain and the pipeline empty
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (rfab_pkg::STAGES + 2) @(negedge clk);
  endtask

  function automatic logic [rfab_pkg::DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return rfab_pkg::MAX_DIMENSION;
      2:       return rfab_pkg::DIM_W'($urandom_range(32767, 16385));
      3:       return rfab_pkg::DIM_W'(1);
      default: return rfab_pkg::DIM_W'($urandom_range(96, 1));
    endcase
  endfunction

  function automatic logic [rfab_pkg::EDGE_W-1:0] rand_edge(input int span);
    int v;
    case ($urandom_range(0, 7))
      0:       v = $urandom;
      1:       v = -int'($urandom_range(40, 1));
      default: v = int'($urandom_range(span + 10, 0)) - 5;
    endcase
    return v[rfab_pkg::EDGE_W-1:0];
  endfunction

  function automatic logic [rfab_pkg::CHAN_W-1:0] rand_alpha();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return rfab_pkg::CHAN_MAX;
      2:       return 8'd1;
      default: return rfab_pkg::CHAN_W'($urandom);
    endcase
  endfunction

  // coordinate near the clipped span, sometimes anywhere
  function automatic logic [rfab_pkg::POS_W-1:0] rand_coord(input int lo, input int hi);
    int a, z;
    if ($urandom_range(0, 5) == 0) return rfab_pkg::POS_W'($urandom);
    a = ((lo < hi) ? lo : hi) - 4;
    z = ((lo < hi) ? hi : lo) + 4;
    if (a < 0) a = 0;
    if (z > 16383) z = 16383;
    if (a > z) a = z;
    return rfab_pkg::POS_W'($urandom_range(z, a));
  endfunction

  function automatic logic [rfab_pkg::PIX_W-1:0] rand_dst();
    logic [rfab_pkg::PIX_W-1:0] d;
    d = $urandom;
    case ($urandom_range(0, 5))
      0:       d[31:24] = '0;
      1:       d[31:24] = rfab_pkg::CHAN_MAX;
      default: ;
    endcase
    return d;
  endfunction

  // write every register with random content, upper data bits random too
  task automatic randomize_config();
    logic [rfab_pkg::CFG_DATA_W-1:0] d;
    int w, h;
    d = $urandom; d[rfab_pkg::DIM_W-1:0] = rand_dim();
    cfg_write(rfab_pkg::REG_FRAME_WIDTH, d);
    d = $urandom; d[rfab_pkg::DIM_W-1:0] = rand_dim();
    cfg_write(rfab_pkg::REG_FRAME_HEIGHT, d);
    w = frame_span(m_frame_w);
    h = frame_span(m_frame_h);
    d = $urandom; d[rfab_pkg::EDGE_W-1:0] = rand_edge(w);
    cfg_write(rfab_pkg::REG_RECT_LEFT, d);
    d = $urandom; d[rfab_pkg::EDGE_W-1:0] = rand_edge(h);
    cfg_write(rfab_pkg::REG_RECT_TOP, d);
    d = $urandom; d[rfab_pkg::EDGE_W-1:0] = rand_edge(w);
    cfg_write(rfab_pkg::REG_RECT_RIGHT, d);
    d = $urandom; d[rfab_pkg::EDGE_W-1:0] = rand_edge(h);
    cfg_write(rfab_pkg::REG_RECT_BOTTOM, d);
    cfg_write(rfab_pkg::REG_FILL_COLOR, $urandom);
    d = $urandom; d[rfab_pkg::CHAN_W-1:0] = rand_alpha();
    cfg_write(rfab_pkg::REG_FILL_ALPHA, d);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(rfab_pkg::CFG_IDX_W'($urandom_range(15, 8)), $urandom);
    end
    cfg_finish();
  endtask

  // random pixels aimed around the clipped rectangle
  task automatic random_pixels(input int count);
    int w, h;
    w = frame_span(m_frame_w);
    h = frame_span(m_frame_h);
    repeat (count) begin
      send_pixel(rand_coord(edge_clip(m_left, w), edge_clip(m_right, w)),
                 rand_coord(edge_clip(m_top, h), edge_clip(m_bottom, h)),
                 rand_dst());
    end
  endtask

  // reset registers give an empty rectangle: everything passes
  task automatic test_reset_values();
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    settle_block();
  endtask

  // rectangle edges and the alpha extremes
  task automatic test_blend_extremes();
    cfg_write(rfab_pkg::REG_FRAME_WIDTH, 32'd64);
    cfg_write(rfab_pkg::REG_FRAME_HEIGHT, 32'd64);
    set_rect(2, 3, 10, 9);
    cfg_write(rfab_pkg::REG_FILL_COLOR, 32'h123456);
    cfg_write(rfab_pkg::REG_FILL_ALPHA, 32'd255);
    cfg_finish();
    send_pixel(14'd2, 14'd3, 32'h80FF00AA);
    send_pixel(14'd9, 14'd8, 32'hFFFFFFFF);
    send_pixel(14'd10, 14'd3, 32'h80FF00AA);
    send_pixel(14'd2, 14'd9, 32'h80FF00AA);
    send_pixel(14'd1, 14'd3, 32'h80FF00AA);
    settle_block();
    // nearly transparent white fill
    cfg_write(rfab_pkg::REG_FILL_COLOR, 32'hFFFFFF);
    cfg_write(rfab_pkg::REG_FILL_ALPHA, 32'd1);
    cfg_finish();
    send_pixel(14'd5, 14'd5, 32'h00000000);
    send_pixel(14'd5, 14'd5, 32'hFFFFFFFF);
    send_pixel(14'd5, 14'd5, 32'h01FF00FF);
    settle_block();
    // half alpha black fill
    cfg_write(rfab_pkg::REG_FILL_COLOR, 32'h000000);
    cfg_write(rfab_pkg::REG_FILL_ALPHA, 32'd128);
    cfg_finish();
    send_pixel(14'd5, 14'd5, 32'hFF808080);
    send_pixel(14'd5, 14'd5, 32'h00123456);
    settle_block();
    // zero alpha disables the fill
    cfg_write(rfab_pkg::REG_FILL_ALPHA, 32'd0);
    cfg_finish();
    send_pixel(14'd5, 14'd5, 32'h7F7F7F7F);
    settle_block();
  endtask

  // frame clamping, inverted rectangles, unmapped register index
  task automatic test_clamp_cases();
    // zero width frame
    cfg_write(rfab_pkg::REG_FRAME_WIDTH, 32'd0);
    cfg_write(rfab_pkg::REG_FRAME_HEIGHT, 32'd16);
    set_rect(-100, -100, 100, 100);
    cfg_write(rfab_pkg::REG_FILL_COLOR, 32'hA0B0C0);
    cfg_write(rfab_pkg::REG_FILL_ALPHA, 32'd200);
    cfg_finish();
    send_pixel(14'd0, 14'd0, 32'h40404040);
    settle_block();
    // frame above the maximum saturates
    cfg_write(rfab_pkg::REG_FRAME_WIDTH, 32'd32767);
    cfg_write(rfab_pkg::REG_FRAME_HEIGHT, 32'd20000);
    set_rect(-5, -1, 32767, 32767);
    cfg_finish();
    send_pixel('1, '1, 32'hC0102030);
    send_pixel('0, '0, 32'h00FFFFFF);
    settle_block();
    // edges at the signed extremes, pixels outside the frame
    cfg_write(rfab_pkg::REG_FRAME_WIDTH, 32'd16);
    cfg_write(rfab_pkg::REG_FRAME_HEIGHT, 32'd16);
    set_rect(-32768, -32768, 32767, 32767);
    cfg_finish();
    send_pixel(14'd15, 14'd15, 32'h11223344);
    send_pixel(14'd16, 14'd0, 32'h11223344);
    send_pixel(14'd0, 14'h3FFF, 32'h11223344);
    settle_block();
    // write to an unmapped index must leave the rectangle alone
    cfg_write(REG_UNMAPPED, 32'd0);
    cfg_finish();
    send_pixel(14'd6, 14'd6, 32'h99887766);
    settle_block();
    // inverted rectangle
    set_rect(10, 10, 4, 4);
    cfg_finish();
    send_pixel(14'd6, 14'd6, 32'h99887766);
    settle_block();
  endtask

  // many random settings, each followed by a full drain
  task automatic test_random_fill(input int phases, input int per_phase);
    repeat (phases) begin
      randomize_config();
      random_pixels(per_phase);
      settle_block();
    end
  endtask

  // back to back items with no idling on either side
  task automatic test_steady_stream();
    idling = 1'b0;
    randomize_config();
    random_pixels(60);
    settle_block();
    randomize_config();
    random_pixels(60);
    settle_block();
  endtask

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (rst || !idling) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(14, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checking against the oldest expectation, plus run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rect_fill_alpha_over_blend regression: fail");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        $error("result with no item pending: out_pixel %h covered %b", out_pixel, covered);
        fail_count++;
      end else begin
        want = pending_px.pop_front();
        if (out_pixel !== want.pixel) begin
          $error("out_pixel expected %h actual %h", want.pixel, out_pixel);
          fail_count++;
        end
        if (covered !== want.cov) begin
          $error("covered expected %b actual %b", want.cov, covered);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    dst_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    m_frame_w = rfab_pkg::RST_FRAME_WIDTH;
    m_frame_h = rfab_pkg::RST_FRAME_HEIGHT;
    m_left    = '0;
    m_top     = '0;
    m_right   = '0;
    m_bottom  = '0;
    m_color   = '0;
    m_alpha   = rfab_pkg::RST_FILL_ALPHA;
    // reset held high, then released on a falling edge
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_blend_extremes();
    test_clamp_cases();
    test_random_fill(30, 47);
    test_steady_stream();
    settle_block();
    if (fail_count == 0) begin
      $display("rect_fill_alpha_over_blend regression: pass");
    end else begin
      $display("rect_fill_alpha_over_blend regression: fail");
    end
    $finish;
  end

endmodule
